### rtl/core/imucf_pkg.sv
// Shared types, constants and helper functions of the complementary tilt filter.
`timescale 1ns / 1ps
package imucf_pkg;

	// Datapath micro-operations issued by the controller.
	typedef enum logic [5:0] {
		OP_NOP,
		OP_LOAD,
		OP_CAL_ACC,
		OP_DIV_MUL,
		OP_DIV_Q,
		OP_DIV_MUL2,
		OP_DIV_FIX,
		OP_MUL_GX,
		OP_ADD_P_MUL_GY,
		OP_ADD_R_MUL_T,
		OP_TAKE_T,
		OP_MUL_MM,
		OP_MUL_HM,
		OP_MUL_H3,
		OP_SINE,
		OP_MUL_RS,
		OP_ADD_P,
		OP_MUL_PS,
		OP_SUB_R,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQ_Z,
		OP_SQ_END,
		OP_RT_INIT,
		OP_RT_STEP,
		OP_CD_INIT,
		OP_CD_STEP,
		OP_CD_MUL,
		OP_CD_END,
		OP_ADOPT,
		OP_BL_OLD,
		OP_BL_NEW,
		OP_BL_WR,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [4:0] idx;  // iteration step
		logic [1:0] sel;  // axis, divider lane or blend target
	} dp_cmd_t;

	typedef struct packed {
		logic cal_active;
		logic cal_last;
		logic started;
	} dp_sts_t;

	// Configuration register indexes
	localparam logic [0:0] REG_DRIFT  = 1'b0;
	localparam logic [0:0] REG_SMOOTH = 1'b1;

	localparam logic [16:0] DRIFT_RESET  = 17'd26;
	localparam logic [16:0] SMOOTH_RESET = 17'd6554;
	localparam logic [16:0] W_ONE        = 17'd65536;

	localparam logic [32:0] K_INT   = 33'd262423;   // 0.0000611 in Q32
	localparam logic [32:0] K_YAW   = 33'd4578;     // 0.000001066 in Q32
	localparam logic [32:0] K_THIRD = 33'd5592405;  // floor(2^24 / 3)
	localparam logic [32:0] K_DEG   = 33'd3754951;  // 57.296 in Q16

	localparam logic [4:0] RT_LAST = 5'd25;
	localparam logic [4:0] CD_LAST = 5'd23;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -68'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Arctangent of 2^-i in Q30 radians, truncated.
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0: r = 30'd843314856;
			5'd1: r = 30'd497837829;
			5'd2: r = 30'd263043836;
			5'd3: r = 30'd133525158;
			5'd4: r = 30'd67021686;
			5'd5: r = 30'd33543515;
			5'd6: r = 30'd16775850;
			5'd7: r = 30'd8388437;
			5'd8: r = 30'd4194282;
			5'd9: r = 30'd2097149;
			default: r = (30'd1 << (5'd30 - i)) - 30'd1;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/imucf_ctrl.sv
// Sequencer of the tilt filter: walks the datapath through calibration and filtering.
`timescale 1ns / 1ps
module imucf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  imucf_pkg::dp_sts_t sts,
	output imucf_pkg::dp_cmd_t cmd
);
	import imucf_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE, ST_CAL, ST_DIV_MUL, ST_DIV_Q, ST_DIV_MUL2, ST_DIV_FIX,
		ST_MUL_GX, ST_ADD_P_GY, ST_ADD_R_T, ST_TAKE_T, ST_MUL_MM, ST_MUL_HM,
		ST_MUL_H3, ST_SINE, ST_MUL_RS, ST_ADD_P, ST_MUL_PS, ST_SUB_R,
		ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_END,
		ST_RT_INIT, ST_RT_STEP, ST_CD_INIT, ST_CD_STEP, ST_CD_MUL, ST_CD_END,
		ST_ADOPT, ST_BL_OLD, ST_BL_NEW, ST_BL_WR, ST_OUT
	} state_t;

	state_t     state_q;
	logic [4:0] idx_q;
	logic [1:0] sel_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.idx = idx_q;
		cmd.sel = sel_q;
		case (state_q)
			ST_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NOP;
			ST_CAL:      cmd.op = OP_CAL_ACC;
			ST_DIV_MUL:  cmd.op = OP_DIV_MUL;
			ST_DIV_Q:    cmd.op = OP_DIV_Q;
			ST_DIV_MUL2: cmd.op = OP_DIV_MUL2;
			ST_DIV_FIX:  cmd.op = OP_DIV_FIX;
			ST_MUL_GX:   cmd.op = OP_MUL_GX;
			ST_ADD_P_GY: cmd.op = OP_ADD_P_MUL_GY;
			ST_ADD_R_T:  cmd.op = OP_ADD_R_MUL_T;
			ST_TAKE_T:   cmd.op = OP_TAKE_T;
			ST_MUL_MM:   cmd.op = OP_MUL_MM;
			ST_MUL_HM:   cmd.op = OP_MUL_HM;
			ST_MUL_H3:   cmd.op = OP_MUL_H3;
			ST_SINE:     cmd.op = OP_SINE;
			ST_MUL_RS:   cmd.op = OP_MUL_RS;
			ST_ADD_P:    cmd.op = OP_ADD_P;
			ST_MUL_PS:   cmd.op = OP_MUL_PS;
			ST_SUB_R:    cmd.op = OP_SUB_R;
			ST_SQ_X:     cmd.op = OP_SQ_X;
			ST_SQ_Y:     cmd.op = OP_SQ_Y;
			ST_SQ_Z:     cmd.op = OP_SQ_Z;
			ST_SQ_END:   cmd.op = OP_SQ_END;
			ST_RT_INIT:  cmd.op = OP_RT_INIT;
			ST_RT_STEP:  cmd.op = OP_RT_STEP;
			ST_CD_INIT:  cmd.op = OP_CD_INIT;
			ST_CD_STEP:  cmd.op = OP_CD_STEP;
			ST_CD_MUL:   cmd.op = OP_CD_MUL;
			ST_CD_END:   cmd.op = OP_CD_END;
			ST_ADOPT:    cmd.op = OP_ADOPT;
			ST_BL_OLD:   cmd.op = OP_BL_OLD;
			ST_BL_NEW:   cmd.op = OP_BL_NEW;
			ST_BL_WR:    cmd.op = OP_BL_WR;
			ST_OUT:      cmd.op = out_free ? OP_OUT : OP_NOP;
			default:     cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result reloads the output register as the old one leaves
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					sel_q <= '0;
					if (in_valid)
						state_q <= sts.cal_active ? ST_CAL : ST_MUL_GX;
				end
				ST_CAL:      state_q <= sts.cal_last ? ST_DIV_MUL : ST_IDLE;
				ST_DIV_MUL:  state_q <= ST_DIV_Q;
				ST_DIV_Q:    state_q <= ST_DIV_MUL2;
				ST_DIV_MUL2: state_q <= ST_DIV_FIX;
				ST_DIV_FIX: begin
					if (sel_q == 2'd2) begin
						state_q <= ST_IDLE;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= ST_DIV_MUL;
					end
				end
				ST_MUL_GX:   state_q <= ST_ADD_P_GY;
				ST_ADD_P_GY: state_q <= ST_ADD_R_T;
				ST_ADD_R_T:  state_q <= ST_TAKE_T;
				ST_TAKE_T:   state_q <= ST_MUL_MM;
				ST_MUL_MM:   state_q <= ST_MUL_HM;
				ST_MUL_HM:   state_q <= ST_MUL_H3;
				ST_MUL_H3:   state_q <= ST_SINE;
				ST_SINE:     state_q <= ST_MUL_RS;
				ST_MUL_RS:   state_q <= ST_ADD_P;
				ST_ADD_P:    state_q <= ST_MUL_PS;
				ST_MUL_PS:   state_q <= ST_SUB_R;
				ST_SUB_R:    state_q <= ST_SQ_X;
				ST_SQ_X:     state_q <= ST_SQ_Y;
				ST_SQ_Y:     state_q <= ST_SQ_Z;
				ST_SQ_Z:     state_q <= ST_SQ_END;
				ST_SQ_END:   state_q <= ST_RT_INIT;
				ST_RT_INIT: begin
					idx_q   <= '0;
					state_q <= ST_RT_STEP;
				end
				ST_RT_STEP: begin
					if (idx_q == RT_LAST) begin
						idx_q   <= '0;
						state_q <= ST_CD_INIT;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				ST_CD_INIT:  state_q <= ST_CD_STEP;
				ST_CD_STEP: begin
					if (idx_q == CD_LAST) begin
						idx_q   <= '0;
						state_q <= ST_CD_MUL;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				ST_CD_MUL:   state_q <= ST_CD_END;
				ST_CD_END: begin
					if (sel_q == 2'd0) begin
						sel_q   <= 2'd1;
						state_q <= ST_RT_INIT;
					end else begin
						sel_q   <= sts.started ? 2'd0 : 2'd2;
						state_q <= sts.started ? ST_BL_OLD : ST_ADOPT;
					end
				end
				ST_ADOPT:    state_q <= ST_BL_OLD;
				ST_BL_OLD:   state_q <= ST_BL_NEW;
				ST_BL_NEW:   state_q <= ST_BL_WR;
				ST_BL_WR: begin
					if (sel_q == 2'd3) begin
						state_q <= ST_OUT;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= ST_BL_OLD;
					end
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/imucf_datapath.sv
// Datapath of the tilt filter: shared multiplier, root and CORDIC units, filter state.
`timescale 1ns / 1ps
module imucf_datapath #(
	parameter int CAL_SAMPLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  imucf_pkg::dp_cmd_t cmd,
	output imucf_pkg::dp_sts_t sts,
	input  logic [95:0]        in_data,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	output logic [127:0]       out_data
);
	import imucf_pkg::*;

	localparam int          CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam logic [32:0] RECIP = 33'((64'd1 << 31) / CAL_SAMPLES);
	localparam logic [32:0] CAL_K = 33'(CAL_SAMPLES);

	// filter state
	logic [CNT_W-1:0]    cal_cnt_q;
	logic signed [26:0]  sum_q [3];
	logic signed [15:0]  off_q [3];
	logic signed [31:0]  pitch_q, roll_q, pout_q, rout_q;
	logic                started_q;
	logic [16:0]         drift_q, smooth_q;

	// working registers
	logic signed [15:0]  ax_q, ay_q, az_q;
	logic signed [15:0]  rate_q [3];
	logic signed [65:0]  prod_q, acc_q;
	logic [29:0]         m_q;
	logic                tneg_q;
	logic [21:0]         h_q;
	logic signed [31:0]  s_q;
	logic [30:0]         sq_q [3];
	logic [51:0]         rem_q, res_q;
	logic signed [29:0]  cx_q, cy_q;
	logic signed [32:0]  cz_q;
	logic                zero_q;
	logic signed [31:0]  pa_q, ra_q;
	logic [25:0]         q_q;
	logic [127:0]        out_q;

	logic signed [32:0]  mul_a, mul_b;
	logic signed [16:0]  g [3];
	logic [26:0]         sum_abs;
	logic [27:0]         div_rem;
	logic [25:0]         q_fix;
	logic signed [65:0]  rnd16, rnd32, cd_rnd;
	logic signed [66:0]  bl_sum, bl_rnd;
	logic [65:0]         t_abs;
	logic [20:0]         q0;
	logic [22:0]         q0x3, third_rem;
	logic [20:0]         q_third;
	logic [29:0]         s_mag;
	logic [31:0]         other_sq;
	logic [51:0]         bitv, trial;
	logic signed [15:0]  num;
	logic signed [29:0]  xs, ys;
	logic signed [32:0]  ent;
	logic signed [31:0]  ang;
	logic [16:0]         w_raw, wt, wc;
	logic signed [31:0]  old_v, tgt_v;

	always_comb begin
		for (int k = 0; k < 3; k++)
			g[k] = 17'(rate_q[k]) - 17'(off_q[k]);
	end

	assign sum_abs  = sum_q[cmd.sel][26] ? 27'(-sum_q[cmd.sel]) : 27'(sum_q[cmd.sel]);
	assign div_rem  = {1'b0, sum_abs} - prod_q[27:0];
	assign q_fix    = q_q + 26'(div_rem >= CAL_K[27:0]);

	assign rnd16    = (prod_q + 66'sd32768) >>> 16;
	assign rnd32    = (prod_q + 66'sd2147483648) >>> 32;
	assign cd_rnd   = (prod_q + 66'sd536870912) >>> 30;
	assign bl_sum   = 67'(acc_q) + 67'(prod_q);
	assign bl_rnd   = (bl_sum + 67'sd32768) >>> 16;

	// sine: s = m - floor(floor(m^3 / 2^64) / 6), the divide by three by reciprocal
	assign t_abs     = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
	assign q0        = prod_q[44:24];
	assign q0x3      = {1'b0, q0, 1'b0} + {2'b0, q0};
	assign third_rem = {1'b0, h_q} - q0x3;
	assign q_third   = q0 + 21'(third_rem >= 23'd3);
	assign s_mag     = m_q - 30'(q_third);

	assign other_sq = cmd.sel[0] ? ({1'b0, sq_q[1]} + {1'b0, sq_q[2]})
	                             : ({1'b0, sq_q[0]} + {1'b0, sq_q[2]});
	assign bitv     = 52'd1 << (6'd50 - {cmd.idx, 1'b0});
	assign trial    = res_q + bitv;

	assign num = cmd.sel[0] ? ax_q : ay_q;
	assign xs  = cx_q >>> cmd.idx;
	assign ys  = cy_q >>> cmd.idx;
	assign ent = {3'b0, atan_q30(cmd.idx)};
	assign ang = zero_q ? 32'sd0 : cd_rnd[31:0];

	assign w_raw = cmd.sel[1] ? smooth_q : drift_q;
	assign wt    = (w_raw > W_ONE) ? W_ONE : w_raw;
	assign wc    = W_ONE - wt;

	always_comb begin
		case (cmd.sel)
			2'd0:    begin old_v = pitch_q; tgt_v = pa_q;    end
			2'd1:    begin old_v = roll_q;  tgt_v = ra_q;    end
			2'd2:    begin old_v = pout_q;  tgt_v = pitch_q; end
			default: begin old_v = rout_q;  tgt_v = roll_q;  end
		endcase
	end

	// operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_DIV_MUL:      begin mul_a = {6'b0, sum_abs};      mul_b = RECIP;   end
			OP_DIV_MUL2:     begin mul_a = {7'b0, q_q};          mul_b = CAL_K;   end
			OP_MUL_GX:       begin mul_a = 33'(g[0]);            mul_b = K_INT;   end
			OP_ADD_P_MUL_GY: begin mul_a = 33'(g[1]);            mul_b = K_INT;   end
			OP_ADD_R_MUL_T:  begin mul_a = 33'(g[2]);            mul_b = K_YAW;   end
			OP_MUL_MM:       begin mul_a = {3'b0, m_q};          mul_b = {3'b0, m_q}; end
			OP_MUL_HM:       begin mul_a = {7'b0, prod_q[57:32]}; mul_b = {3'b0, m_q}; end
			OP_MUL_H3:       begin mul_a = {11'b0, prod_q[54:33]}; mul_b = K_THIRD; end
			OP_MUL_RS:       begin mul_a = 33'(roll_q);          mul_b = 33'(s_q); end
			OP_MUL_PS:       begin mul_a = 33'(pitch_q);         mul_b = 33'(s_q); end
			OP_SQ_X:         begin mul_a = 33'(ax_q);            mul_b = 33'(ax_q); end
			OP_SQ_Y:         begin mul_a = 33'(ay_q);            mul_b = 33'(ay_q); end
			OP_SQ_Z:         begin mul_a = 33'(az_q);            mul_b = 33'(az_q); end
			OP_CD_MUL:       begin mul_a = cz_q;                 mul_b = K_DEG;   end
			OP_BL_OLD:       begin mul_a = 33'(old_v);           mul_b = {16'b0, wc}; end
			OP_BL_NEW:       begin mul_a = 33'(tgt_v);           mul_b = {16'b0, wt}; end
			default:         begin mul_a = '0;                   mul_b = '0;      end
		endcase
	end

	assign sts.cal_active = (cal_cnt_q < CNT_W'(CAL_SAMPLES));
	assign sts.cal_last   = (cal_cnt_q == CNT_W'(CAL_SAMPLES - 1));
	assign sts.started    = started_q;
	assign out_data       = out_q;

	// state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cnt_q <= '0;
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= '0;
				off_q[k] <= '0;
			end
			pitch_q   <= '0;
			roll_q    <= '0;
			pout_q    <= '0;
			rout_q    <= '0;
			started_q <= 1'b0;
			drift_q   <= DRIFT_RESET;
			smooth_q  <= SMOOTH_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DRIFT:  drift_q  <= cfg_data;
					REG_SMOOTH: smooth_q <= cfg_data;
					default:    ;
				endcase
			end
			case (cmd.op)
				OP_CAL_ACC: begin
					for (int k = 0; k < 3; k++)
						sum_q[k] <= sum_q[k] + 27'(rate_q[k]);
					cal_cnt_q <= cal_cnt_q + CNT_W'(1);
				end
				OP_DIV_FIX:
					off_q[cmd.sel] <= sum_q[cmd.sel][26] ? -16'(q_fix) : 16'(q_fix);
				OP_ADD_P_MUL_GY: pitch_q <= sat32(68'(pitch_q) + 68'(rnd16));
				OP_ADD_R_MUL_T:  roll_q  <= sat32(68'(roll_q) + 68'(rnd16));
				OP_ADD_P:        pitch_q <= sat32(68'(pitch_q) + 68'(rnd32));
				OP_SUB_R:        roll_q  <= sat32(68'(roll_q) - 68'(rnd32));
				OP_ADOPT: begin
					pitch_q   <= pa_q;
					roll_q    <= ra_q;
					started_q <= 1'b1;
				end
				OP_BL_WR: begin
					case (cmd.sel)
						2'd0:    pitch_q <= sat32(68'(bl_rnd));
						2'd1:    roll_q  <= sat32(68'(bl_rnd));
						2'd2:    pout_q  <= sat32(68'(bl_rnd));
						default: rout_q  <= sat32(68'(bl_rnd));
					endcase
				end
				default: ;
			endcase
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				ax_q      <= in_data[15:0];
				ay_q      <= in_data[31:16];
				az_q      <= in_data[47:32];
				rate_q[0] <= in_data[63:48];
				rate_q[1] <= in_data[79:64];
				rate_q[2] <= in_data[95:80];
			end
			OP_DIV_Q:  q_q <= prod_q[56:31];
			OP_TAKE_T: begin
				m_q    <= t_abs[29:0];
				tneg_q <= prod_q[65];
			end
			OP_MUL_H3: h_q <= prod_q[54:33];
			OP_SINE:   s_q <= tneg_q ? -32'(s_mag) : 32'(s_mag);
			OP_SQ_Y:   sq_q[0] <= prod_q[30:0];
			OP_SQ_Z:   sq_q[1] <= prod_q[30:0];
			OP_SQ_END: sq_q[2] <= prod_q[30:0];
			OP_RT_INIT: begin
				rem_q <= {other_sq, 20'b0};
				res_q <= '0;
			end
			OP_RT_STEP: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			OP_CD_INIT: begin
				cx_q   <= res_q[29:0];
				cy_q   <= {{4{num[15]}}, num, 10'b0};
				cz_q   <= '0;
				zero_q <= (res_q == 52'd0) && (num == 16'sd0);
			end
			OP_CD_STEP: begin
				if (cy_q > 30'sd0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + ent;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - ent;
				end
			end
			OP_CD_END: begin
				if (cmd.sel[0])
					ra_q <= -ang;
				else
					pa_q <= ang;
			end
			OP_BL_NEW: acc_q <= prod_q;
			OP_OUT:    out_q <= {roll_q, pitch_q, rout_q, pout_q};
			default: ;
		endcase
	end

endmodule

### rtl/core/imu_complementary_tilt_filter_top.sv
// Top level of the complementary pitch/roll tilt filter.
`timescale 1ns / 1ps
// A calibration item adds to the gyro sums, the last one also runs the offset divides;
//   a filtered item runs two 26-step square roots and two 24-step CORDIC runs on one
//   shared unit, and the first one also adopts the accelerometer angles.
// Throughput: one item at a time; the next item is taken once the result is in
//   the output register, which holds it until the sink takes it.
// Reset (arst_n low, asynchronous): calibration restarts, angles and sums clear,
//   weights return to 26 and 6554.
module imu_complementary_tilt_filter_top #(
	parameter int CAL_SAMPLES = 1024  // gyro samples averaged for offsets, 1..1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each, lowest first)
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pitch_smoothed, roll_smoothed, pitch_fused, roll_fused (32 bits each, lowest first)
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,   // 0: drift_weight, 1: smooth_weight
	input  logic [16:0]  cfg_data
);
	import imucf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Controller: sequences calibration sums, offset divides, integration,
	// yaw coupling, tilt angles, drift blend and smoothing.
	imucf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: one shared 33x33 multiplier, bit-pair square root, CORDIC,
	// filter state and the output register.
	imucf_datapath #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata)
	);

endmodule
